>>> rtl/core/dfr_pkg.sv
// Shared types, constants and code tables for the host link message deframer.
`timescale 1ns / 1ps
`default_nettype none
package dfr_pkg;

   localparam int MAX_PAYLOAD = 60;
   localparam int CNT_W       = $clog2(MAX_PAYLOAD + 5);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0]  TIMEOUT_RESET = 8'd10;
   localparam logic [15:0] STATUS_RESET  = 16'hffff;

   // Codes that touch the status registers or raise an action
   localparam logic [15:0] CODE_STARTUP    = 16'h0400;
   localparam logic [15:0] CODE_HF_RESET   = 16'h0401;
   localparam logic [15:0] CODE_GENERAL    = 16'h0406;
   localparam logic [15:0] CODE_PAIR_RSP   = 16'h0200;
   localparam logic [15:0] CODE_HF_IND     = 16'h0420;
   localparam logic [15:0] CODE_HF_RSP     = 16'h022b;
   localparam logic [15:0] CODE_SCO_IND    = 16'h0421;
   localparam logic [15:0] CODE_AUDIO_IND  = 16'h0440;
   localparam logic [15:0] CODE_AUDIO_RSP  = 16'h0244;
   localparam logic [15:0] GENERAL_PAIRING = 16'd2;

   localparam int N_IND = 14;
   localparam logic [15:0] IND_CODES [N_IND] = '{
      16'h0400, 16'h0401, 16'h0402, 16'h0403, 16'h0406, 16'h0407, 16'h0420,
      16'h0421, 16'h0422, 16'h0423, 16'h0427, 16'h0440, 16'h0441, 16'h0460
   };

   typedef enum logic [1:0] {
      EV_DONE     = 2'd0,
      EV_TIMEOUT  = 2'd1,
      EV_MISALIGN = 2'd2,
      EV_TOO_LONG = 2'd3
   } event_type;

   typedef enum logic [1:0] {
      CLASS_UNKNOWN    = 2'd0,
      CLASS_INDICATION = 2'd1,
      CLASS_RESPONSE   = 2'd2
   } class_type;

   typedef enum logic [1:0] {
      ACT_NONE    = 2'd0,
      ACT_STARTUP = 2'd1,
      ACT_PAIRING = 2'd2
   } action_type;

   // One framing event handed from the front end to the back end
   typedef struct packed {
      event_type   ev;
      logic [15:0] code;
      logic [15:0] len;
      logic [15:0] word;
   } frame_event_type;

   typedef struct packed {
      event_type          event_res;
      logic [15:0]        msg_code;
      logic [15:0]        msg_length;
      class_type          msg_class;
      logic [15:0]        first_word;
      action_type         action;
      logic signed [15:0] general_state;
      logic signed [15:0] handsfree_state;
      logic signed [15:0] audio_stream_state;
      logic signed [15:0] voice_link_state;
      logic               paired;
      logic               call_active;
   } result_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic full;
      logic empty;
   } queue_ctl_type;

   function automatic class_type classify(input logic [15:0] code);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < N_IND; i++) begin
         if (IND_CODES[i] == code) begin
            hit = 1'b1;
         end
      end
      if (hit) begin
         return CLASS_INDICATION;
      end
      if ((code >= 16'h0200 && code <= 16'h0204) || (code >= 16'h0206 && code <= 16'h020f) ||
          (code >= 16'h0220 && code <= 16'h022b) || (code >= 16'h0240 && code <= 16'h0245) ||
          code == 16'h0260) begin
         return CLASS_RESPONSE;
      end
      return CLASS_UNKNOWN;
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/dfr_channels.sv
// Handshake channel interfaces for request, response and control write beats.
`timescale 1ns / 1ps
`default_nettype none
interface dfr_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] rx_byte;
   modport source (output valid, kind, rx_byte, input ready);
   modport sink (input valid, kind, rx_byte, output ready);
endinterface

interface dfr_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         event_res;
   logic [15:0]        msg_code;
   logic [15:0]        msg_length;
   logic [1:0]         msg_class;
   logic [15:0]        first_word;
   logic [1:0]         action;
   logic signed [15:0] general_state;
   logic signed [15:0] handsfree_state;
   logic signed [15:0] audio_stream_state;
   logic signed [15:0] voice_link_state;
   logic               paired;
   logic               call_active;
   modport source (output valid, event_res, msg_code, msg_length, msg_class, first_word,
                   action, general_state, handsfree_state, audio_stream_state,
                   voice_link_state, paired, call_active, input ready);
   modport sink (input valid, event_res, msg_code, msg_length, msg_class, first_word,
                 action, general_state, handsfree_state, audio_stream_state,
                 voice_link_state, paired, call_active, output ready);
endinterface

interface dfr_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] timeout_ticks;
   modport source (output valid, timeout_ticks, input ready);
   modport sink (input valid, timeout_ticks, output ready);
endinterface
`default_nettype wire

>>> rtl/core/host_link_message_deframer_core.sv
// Top level of the host link message deframer: front end, event queue, back end.
// A result reaches rsp_ch by way of the event queue, which registers the beat's
// framing event, and then the result register.
// Throughput: one request beat per cycle; request ready drops only while the
// two-entry event queue is full, which happens when the response side stalls.
// Reset (synchronous, active high) empties the queue and result register, clears the
// frame, and sets timeout_ticks to 10 and all four status registers to 0xffff.
`timescale 1ns / 1ps
`default_nettype none
module host_link_message_deframer_core (
   input wire logic  clock,
   input wire logic  reset,
   dfr_req_if.sink   req_ch,
   dfr_rsp_if.source rsp_ch,
   dfr_csr_if.sink   csr_ch
);

   logic [7:0]                timeout_ff, timeout_in;
   logic                      req_beat;
   logic                      push;
   logic                      pop;
   dfr_pkg::frame_event_type  push_data;
   dfr_pkg::frame_event_type  pop_data;
   dfr_pkg::queue_ctl_type    qctl;
   dfr_pkg::result_type       result;

   // Control register: writes are always taken
   assign csr_ch.ready = 1'b1;
   assign timeout_in   = csr_ch.valid ? csr_ch.timeout_ticks : timeout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= dfr_pkg::TIMEOUT_RESET;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

   // Hold off request beats only when the event queue has no room
   assign req_ch.ready = !qctl.full;
   assign req_beat     = req_ch.valid && req_ch.ready;

   dfr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .beat          (req_beat),
      .kind          (req_ch.kind),
      .rx_byte       (req_ch.rx_byte),
      .timeout_ticks (timeout_ff),
      .push          (push),
      .push_data     (push_data)
   );

   dfr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .ctl       (qctl)
   );

   dfr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .have_event (!qctl.empty),
      .ev_data    (pop_data),
      .pop        (pop),
      .out_valid  (rsp_ch.valid),
      .out_ready  (rsp_ch.ready),
      .out_data   (result)
   );

   // Drive the response payload from the result register
   assign rsp_ch.event_res          = result.event_res;
   assign rsp_ch.msg_code           = result.msg_code;
   assign rsp_ch.msg_length         = result.msg_length;
   assign rsp_ch.msg_class          = result.msg_class;
   assign rsp_ch.first_word         = result.first_word;
   assign rsp_ch.action             = result.action;
   assign rsp_ch.general_state      = result.general_state;
   assign rsp_ch.handsfree_state    = result.handsfree_state;
   assign rsp_ch.audio_stream_state = result.audio_stream_state;
   assign rsp_ch.voice_link_state   = result.voice_link_state;
   assign rsp_ch.paired             = result.paired;
   assign rsp_ch.call_active        = result.call_active;

endmodule
`default_nettype wire

>>> rtl/core/dfr_front.sv
// Front end: frames link bytes, runs the partial-frame timer and emits framing events.
`timescale 1ns / 1ps
`default_nettype none
module dfr_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     beat,
   input  wire logic                     kind,
   input  wire logic [7:0]               rx_byte,
   input  wire logic [7:0]               timeout_ticks,
   output logic                          push,
   output dfr_pkg::frame_event_type      push_data
);

   logic [dfr_pkg::CNT_W-1:0] count_ff, count_in;
   logic [31:0]               hdr_ff, hdr_in;
   logic [15:0]               pfirst_ff, pfirst_in;
   logic                      misal_ff, misal_in;
   logic [7:0]                wait_ff, wait_in;

   logic [31:0]               hdr_new;
   logic [15:0]               pf_new;
   logic [dfr_pkg::CNT_W-1:0] frame_end;
   logic [dfr_pkg::CNT_W-1:0] count_inc;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         hdr_ff    <= '0;
         pfirst_ff <= '0;
         misal_ff  <= 1'b0;
         wait_ff   <= '0;
      end else begin
         count_ff  <= count_in;
         hdr_ff    <= hdr_in;
         pfirst_ff <= pfirst_in;
         misal_ff  <= misal_in;
         wait_ff   <= wait_in;
      end
   end

   // Length is known to be within the buffer once the payload phase runs
   assign frame_end = dfr_pkg::CNT_W'(hdr_ff[31:16]) + dfr_pkg::CNT_W'(4);
   assign count_inc = count_ff + dfr_pkg::CNT_W'(1);

   always_comb begin
      hdr_new = hdr_ff;
      unique case (count_ff[1:0])
         2'd0:    hdr_new[7:0]   = rx_byte;
         2'd1:    hdr_new[15:8]  = rx_byte;
         2'd2:    hdr_new[23:16] = rx_byte;
         default: hdr_new[31:24] = rx_byte;
      endcase
      pf_new = pfirst_ff;
      if (count_ff == dfr_pkg::CNT_W'(4)) begin
         pf_new[7:0] = rx_byte;
      end else if (count_ff == dfr_pkg::CNT_W'(5)) begin
         pf_new[15:8] = rx_byte;
      end
   end

   always_comb begin
      count_in  = count_ff;
      hdr_in    = hdr_ff;
      pfirst_in = pfirst_ff;
      misal_in  = misal_ff;
      wait_in   = wait_ff;
      push      = 1'b0;
      push_data = '0;
      if (beat) begin
         if (kind) begin
            // Timer tick: only counts while a frame is partly received
            if (count_ff != '0) begin
               if (wait_ff >= timeout_ticks) begin
                  count_in     = '0;
                  hdr_in       = '0;
                  pfirst_in    = '0;
                  wait_in      = '0;
                  misal_in     = 1'b0;
                  push         = 1'b1;
                  push_data.ev = dfr_pkg::EV_TIMEOUT;
               end else begin
                  wait_in = wait_ff + 8'd1;
               end
            end
         end else if (count_ff < dfr_pkg::CNT_W'(4)) begin
            hdr_in   = hdr_new;
            count_in = count_inc;
            if (count_ff == dfr_pkg::CNT_W'(3)) begin
               push_data.code = hdr_new[15:0];
               push_data.len  = hdr_new[31:16];
               priority if (misal_ff) begin
                  push_data.ev = dfr_pkg::EV_MISALIGN;
                  push         = 1'b1;
                  misal_in     = 1'b0;
               end else if (hdr_new[31:16] > 16'(dfr_pkg::MAX_PAYLOAD)) begin
                  push_data.ev = dfr_pkg::EV_TOO_LONG;
                  push         = 1'b1;
               end else if (hdr_new[31:16] == 16'd0) begin
                  push_data.ev = dfr_pkg::EV_DONE;
                  push         = 1'b1;
                  misal_in     = 1'b0;
               end else begin
                  // Header accepted: advance into the payload
                  push = 1'b0;
               end
               if (push) begin
                  count_in  = '0;
                  hdr_in    = '0;
                  pfirst_in = '0;
                  wait_in   = '0;
               end
            end
         end else begin
            pfirst_in = pf_new;
            count_in  = count_inc;
            if (count_inc == frame_end) begin
               push           = 1'b1;
               push_data.ev   = dfr_pkg::EV_DONE;
               push_data.code = hdr_ff[15:0];
               push_data.len  = hdr_ff[31:16];
               push_data.word = (hdr_ff[31:16] >= 16'd2) ? pf_new : 16'd0;
               misal_in       = hdr_ff[16];
               count_in       = '0;
               hdr_in         = '0;
               pfirst_in      = '0;
               wait_in        = '0;
            end
         end
      end
   end

endmodule
`default_nettype wire

>>> rtl/core/dfr_queue.sv
// Short event queue between the framing front end and the status back end.
`timescale 1ns / 1ps
`default_nettype none
module dfr_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire dfr_pkg::frame_event_type  push_data,
   input  wire logic                      pop,
   output dfr_pkg::frame_event_type       pop_data,
   output dfr_pkg::queue_ctl_type         ctl
);

   dfr_pkg::frame_event_type mem [dfr_pkg::QUEUE_DEPTH];

   logic [dfr_pkg::QPTR_W-1:0] wr_ff, wr_in;
   logic [dfr_pkg::QPTR_W-1:0] rd_ff, rd_in;
   logic [dfr_pkg::QCNT_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= push_data;
      end
   end

   always_comb begin
      wr_in  = push ? wr_ff + dfr_pkg::QPTR_W'(1) : wr_ff;
      rd_in  = pop ? rd_ff + dfr_pkg::QPTR_W'(1) : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + dfr_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - dfr_pkg::QCNT_W'(1);
      end
   end

   assign pop_data  = mem[rd_ff];
   assign ctl.push  = push;
   assign ctl.pop   = pop;
   assign ctl.full  = (cnt_ff == dfr_pkg::QCNT_W'(dfr_pkg::QUEUE_DEPTH));
   assign ctl.empty = (cnt_ff == '0);

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      push |-> !ctl.full)
      else $error("event queue written while full");

   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      pop |-> !ctl.empty)
      else $error("event queue read while empty");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= dfr_pkg::QCNT_W'(dfr_pkg::QUEUE_DEPTH))
      else $error("event queue count out of range");

   a_push_counts : assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (cnt_ff == $past(cnt_ff) + dfr_pkg::QCNT_W'(1)))
      else $error("event queue count missed a write");

endmodule
`default_nettype wire

>>> rtl/core/dfr_back.sv
// Back end: classes codes, updates status registers and holds the result register.
`timescale 1ns / 1ps
`default_nettype none
module dfr_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      have_event,
   input  wire dfr_pkg::frame_event_type  ev_data,
   output logic                          pop,
   output logic                          out_valid,
   input  wire logic                      out_ready,
   output dfr_pkg::result_type           out_data
);

   logic [15:0] gen_ff, gen_in;
   logic [15:0] hf_ff, hf_in;
   logic [15:0] a2_ff, a2_in;
   logic [15:0] sco_ff, sco_in;
   logic        valid_ff, valid_in;
   dfr_pkg::result_type res_ff, res_in;
   dfr_pkg::action_type act;
   logic        done;

   assign pop      = have_event && (!valid_ff || out_ready);
   assign valid_in = pop || (valid_ff && !out_ready);
   assign done     = (ev_data.ev == dfr_pkg::EV_DONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff   <= dfr_pkg::STATUS_RESET;
         hf_ff    <= dfr_pkg::STATUS_RESET;
         a2_ff    <= dfr_pkg::STATUS_RESET;
         sco_ff   <= dfr_pkg::STATUS_RESET;
         valid_ff <= 1'b0;
      end else begin
         gen_ff   <= gen_in;
         hf_ff    <= hf_in;
         a2_ff    <= a2_in;
         sco_ff   <= sco_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         res_ff <= res_in;
      end
   end

   // Status updates and action requests for a completed message
   always_comb begin
      gen_in = gen_ff;
      hf_in  = hf_ff;
      a2_in  = a2_ff;
      sco_in = sco_ff;
      act    = dfr_pkg::ACT_NONE;
      if (pop && done) begin
         unique case (ev_data.code)
            dfr_pkg::CODE_STARTUP:  act = dfr_pkg::ACT_STARTUP;
            dfr_pkg::CODE_HF_RESET: hf_in = 16'd0;
            dfr_pkg::CODE_GENERAL: begin
               gen_in = ev_data.word;
               if (ev_data.word == dfr_pkg::GENERAL_PAIRING) begin
                  act = dfr_pkg::ACT_PAIRING;
               end
            end
            dfr_pkg::CODE_PAIR_RSP:  act = dfr_pkg::ACT_PAIRING;
            dfr_pkg::CODE_HF_IND,
            dfr_pkg::CODE_HF_RSP:    hf_in = ev_data.word;
            dfr_pkg::CODE_SCO_IND:   sco_in = ev_data.word;
            dfr_pkg::CODE_AUDIO_IND,
            dfr_pkg::CODE_AUDIO_RSP: a2_in = ev_data.word;
            default: ;
         endcase
      end
   end

   always_comb begin
      res_in.event_res          = ev_data.ev;
      res_in.msg_code           = ev_data.code;
      res_in.msg_length         = ev_data.len;
      res_in.msg_class          = done ? dfr_pkg::classify(ev_data.code)
                                       : dfr_pkg::CLASS_UNKNOWN;
      res_in.first_word         = ev_data.word;
      res_in.action             = act;
      res_in.general_state      = $signed(gen_in);
      res_in.handsfree_state    = $signed(hf_in);
      res_in.audio_stream_state = $signed(a2_in);
      res_in.voice_link_state   = $signed(sco_in);
      res_in.paired             = ($signed(gen_in) > 16'sd2) || ($signed(a2_in) > 16'sd0);
      res_in.call_active        = (sco_in == 16'd1);
   end

   assign out_valid = valid_ff;
   assign out_data  = res_ff;

endmodule
`default_nettype wire

>>> bench/host_link_message_deframer_core_test.sv
// Self-checking testbench for the host link message deframer core.
`timescale 1ns / 1ps

// Track the deframer state beat by beat and hold the results it should produce.
class message_tracker;
   logic [7:0]           timeout;
   int                   nbytes;
   logic [31:0]          hdr;
   logic [15:0]          pay_first;
   bit                   misal;
   logic [7:0]           waited;
   logic signed [15:0]   gen_st;
   logic signed [15:0]   hf_st;
   logic signed [15:0]   a2_st;
   logic signed [15:0]   sco_st;
   dfr_pkg::result_type  expected_events[$];
   int                   errors;

   function new();
      timeout = dfr_pkg::TIMEOUT_RESET;
      misal   = 1'b0;
      gen_st  = dfr_pkg::STATUS_RESET;
      hf_st   = dfr_pkg::STATUS_RESET;
      a2_st   = dfr_pkg::STATUS_RESET;
      sco_st  = dfr_pkg::STATUS_RESET;
      errors  = 0;
      clear_frame();
   endfunction

   function void set_timeout(input logic [7:0] v);
      timeout = v;
   endfunction

   function int pending();
      return expected_events.size();
   endfunction

   // A tick outside a frame changes nothing
   function bit idle();
      return nbytes == 0;
   endfunction

   function void clear_frame();
      nbytes    = 0;
      hdr       = '0;
      pay_first = '0;
      waited    = '0;
   endfunction

   function dfr_pkg::class_type code_class(input logic [15:0] c);
      if (c inside {16'h0400, 16'h0401, 16'h0402, 16'h0403, 16'h0406, 16'h0407, 16'h0420,
                    16'h0421, 16'h0422, 16'h0423, 16'h0427, 16'h0440, 16'h0441, 16'h0460})
         return dfr_pkg::CLASS_INDICATION;
      if (c inside {[16'h0200:16'h0204], [16'h0206:16'h020f], [16'h0220:16'h022b],
                    [16'h0240:16'h0245], 16'h0260})
         return dfr_pkg::CLASS_RESPONSE;
      return dfr_pkg::CLASS_UNKNOWN;
   endfunction

   function void report(input dfr_pkg::event_type ev, input logic [15:0] code,
                        input logic [15:0] len, input dfr_pkg::class_type cls,
                        input logic [15:0] word, input dfr_pkg::action_type act);
      dfr_pkg::result_type r;
      r.event_res          = ev;
      r.msg_code           = code;
      r.msg_length         = len;
      r.msg_class          = cls;
      r.first_word         = word;
      r.action             = act;
      r.general_state      = gen_st;
      r.handsfree_state    = hf_st;
      r.audio_stream_state = a2_st;
      r.voice_link_state   = sco_st;
      r.paired             = (gen_st > 2) || (a2_st > 0);
      r.call_active        = (sco_st == 1);
      expected_events.push_back(r);
   endfunction

   // Close a complete message: apply its status update and flag an odd length
   function void complete();
      logic [15:0]         code;
      logic [15:0]         len;
      logic [15:0]         word;
      dfr_pkg::action_type act;
      code = hdr[15:0];
      len  = hdr[31:16];
      word = (len >= 2) ? pay_first : 16'd0;
      act  = dfr_pkg::ACT_NONE;
      case (code)
         dfr_pkg::CODE_STARTUP: act = dfr_pkg::ACT_STARTUP;
         dfr_pkg::CODE_HF_RESET: hf_st = '0;
         dfr_pkg::CODE_GENERAL: begin
            gen_st = word;
            if (word == dfr_pkg::GENERAL_PAIRING) act = dfr_pkg::ACT_PAIRING;
         end
         dfr_pkg::CODE_PAIR_RSP: act = dfr_pkg::ACT_PAIRING;
         dfr_pkg::CODE_HF_IND, dfr_pkg::CODE_HF_RSP: hf_st = word;
         dfr_pkg::CODE_SCO_IND: sco_st = word;
         dfr_pkg::CODE_AUDIO_IND, dfr_pkg::CODE_AUDIO_RSP: a2_st = word;
         default: ;
      endcase
      misal = len[0];
      clear_frame();
      report(dfr_pkg::EV_DONE, code, len, code_class(code), word, act);
   endfunction

   function void note_beat(input bit is_tick, input logic [7:0] b);
      logic [15:0] code;
      logic [15:0] len;
      if (is_tick) begin
         if (nbytes == 0) return;
         if (waited >= timeout) begin
            clear_frame();
            misal = 1'b0;
            report(dfr_pkg::EV_TIMEOUT, '0, '0, dfr_pkg::CLASS_UNKNOWN, '0,
                   dfr_pkg::ACT_NONE);
         end else begin
            waited++;
         end
         return;
      end
      if (nbytes < 4) begin
         hdr[8*nbytes +: 8] = b;
         nbytes++;
         if (nbytes < 4) return;
         code = hdr[15:0];
         len  = hdr[31:16];
         if (misal) begin
            misal = 1'b0;
            clear_frame();
            report(dfr_pkg::EV_MISALIGN, code, len, dfr_pkg::CLASS_UNKNOWN, '0,
                   dfr_pkg::ACT_NONE);
         end else if (len > dfr_pkg::MAX_PAYLOAD) begin
            clear_frame();
            report(dfr_pkg::EV_TOO_LONG, code, len, dfr_pkg::CLASS_UNKNOWN, '0,
                   dfr_pkg::ACT_NONE);
         end else if (len == 0) begin
            complete();
         end
         return;
      end
      len = hdr[31:16];
      if (nbytes - 4 < 2) pay_first[8*(nbytes-4) +: 8] = b;
      nbytes++;
      if (nbytes >= 4 + len) complete();
   endfunction

   function void cmp(input string name, input logic [15:0] e, input logic [15:0] a);
      if (e !== a) begin
         $error("%s: expected 'h%0h, got 'h%0h", name, e, a);
         errors++;
      end
   endfunction

   function void check_result(input dfr_pkg::result_type got);
      dfr_pkg::result_type e;
      if (expected_events.size() == 0) begin
         $error("result beat with nothing expected (event_res %0d)", got.event_res);
         errors++;
         return;
      end
      e = expected_events.pop_front();
      cmp("event_res", e.event_res, got.event_res);
      cmp("msg_code", e.msg_code, got.msg_code);
      cmp("msg_length", e.msg_length, got.msg_length);
      cmp("msg_class", e.msg_class, got.msg_class);
      cmp("first_word", e.first_word, got.first_word);
      cmp("action", e.action, got.action);
      cmp("general_state", e.general_state, got.general_state);
      cmp("handsfree_state", e.handsfree_state, got.handsfree_state);
      cmp("audio_stream_state", e.audio_stream_state, got.audio_stream_state);
      cmp("voice_link_state", e.voice_link_state, got.voice_link_state);
      cmp("paired", e.paired, got.paired);
      cmp("call_active", e.call_active, got.call_active);
   endfunction

   function void final_check();
      if (expected_events.size() != 0) begin
         $error("%0d expected results never arrived", expected_events.size());
         errors++;
      end
   endfunction
endclass

module host_link_message_deframer_core_test;

   // Codes worth hitting often: every status/action code plus a few edge values
   localparam logic [15:0] HOT_CODES [12] = '{
      dfr_pkg::CODE_STARTUP, dfr_pkg::CODE_HF_RESET, dfr_pkg::CODE_GENERAL,
      dfr_pkg::CODE_PAIR_RSP, dfr_pkg::CODE_HF_IND, dfr_pkg::CODE_HF_RSP,
      dfr_pkg::CODE_SCO_IND, dfr_pkg::CODE_AUDIO_IND, dfr_pkg::CODE_AUDIO_RSP,
      16'h0000, 16'hffff, 16'h0205
   };
   localparam bit BEAT_BYTE = 1'b0;
   localparam bit BEAT_TICK = 1'b1;

   typedef enum int {RX_OPEN, RX_LIGHT, RX_PATTERN, RX_HEAVY} rx_mode_type;

   logic clock;
   logic reset;

   dfr_req_if req_ch ();
   dfr_rsp_if rsp_ch ();
   dfr_csr_if csr_ch ();

   message_tracker sb;
   int             items_sent;
   int             burst_left;

   // Receiver stall pattern state
   rx_mode_type rx_mode;
   int          rx_left;
   logic [15:0] rx_pattern;

   host_link_message_deframer_core i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #1 clock = ~clock;

   // Receiver: switch between stall styles, each held for a random stretch, so that
   // back-pressure hits every phase of the frame, with open stretches as well.
   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode    = rx_mode_type'($urandom_range(0, 3));
         rx_left    = $urandom_range(20, 120);
         rx_pattern = $urandom | 16'h1;
      end else begin
         rx_left--;
      end
      case (rx_mode)
         RX_OPEN: rsp_ch.ready <= 1'b1;
         RX_LIGHT: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
         RX_PATTERN: rsp_ch.ready <= rx_pattern[rx_left[3:0]];
         default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // Sample every accepted result beat and check it against the oldest expectation
   always @(posedge clock) begin
      dfr_pkg::result_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.event_res          = dfr_pkg::event_type'(rsp_ch.event_res);
         got.msg_code           = rsp_ch.msg_code;
         got.msg_length         = rsp_ch.msg_length;
         got.msg_class          = dfr_pkg::class_type'(rsp_ch.msg_class);
         got.first_word         = rsp_ch.first_word;
         got.action             = dfr_pkg::action_type'(rsp_ch.action);
         got.general_state      = rsp_ch.general_state;
         got.handsfree_state    = rsp_ch.handsfree_state;
         got.audio_stream_state = rsp_ch.audio_stream_state;
         got.voice_link_state   = rsp_ch.voice_link_state;
         got.paired             = rsp_ch.paired;
         got.call_active        = rsp_ch.call_active;
         sb.check_result(got);
      end
   end

   // Send one request beat. Called at a falling edge, returns at a falling edge
   // with valid still high so back-to-back beats never drop valid in between.
   task automatic send_item(input bit is_tick, input logic [7:0] b);
      int  gap;
      bit  counted;
      // open a new burst, usually after a gap with valid low
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_ch.valid   <= 1'b1;
      req_ch.kind    <= is_tick;
      req_ch.rx_byte <= b;
      do @(posedge clock); while (!req_ch.ready);
      // a tick with no frame open does nothing, so leave it out of the count
      counted = !(is_tick && sb.idle());
      sb.note_beat(is_tick, b);
      if (counted) items_sent++;
      @(negedge clock);
   endtask

   task automatic send_ticks(input int n);
      repeat (n) send_item(BEAT_TICK, 8'h00);
   endtask

   // Send the first `keep` bytes of a message; a too-long length sends the header only.
   // With mid_ticks set, ticks are sprinkled between the bytes.
   task automatic send_message(input logic [15:0] code, input logic [15:0] len,
                               input logic [15:0] word, input int keep, input bit mid_ticks);
      int         total;
      logic [7:0] b;
      total = (len > dfr_pkg::MAX_PAYLOAD) ? 4 : 4 + len;
      for (int i = 0; i < total && i < keep; i++) begin
         if (mid_ticks && i > 0 && $urandom_range(0, 15) == 0) send_item(BEAT_TICK, 8'h00);
         case (i)
            0: b = code[7:0];
            1: b = code[15:8];
            2: b = len[7:0];
            3: b = len[15:8];
            4: b = word[7:0];
            5: b = word[15:8];
            default: b = $urandom_range(0, 255);
         endcase
         send_item(BEAT_BYTE, b);
      end
   endtask

   function automatic logic [15:0] pick_code();
      case ($urandom_range(0, 5))
         0, 1, 2: return HOT_CODES[$urandom_range(0, 11)];
         3: return dfr_pkg::IND_CODES[$urandom_range(0, dfr_pkg::N_IND - 1)];
         4: return 16'h0200 + 16'($urandom_range(0, 16'h6f));
         default: return 16'($urandom_range(0, 16'hffff));
      endcase
   endfunction

   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'h0001;
         2: return dfr_pkg::GENERAL_PAIRING;
         3: return 16'h0003;
         4: return 16'h7fff;
         5: return 16'h8000;
         6: return 16'hffff;
         default: return 16'($urandom_range(0, 16'hffff));
      endcase
   endfunction

   // Keep most payloads short; the buffer limit and over-long lengths now and then
   function automatic logic [15:0] pick_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 72) return 16'($urandom_range(0, 6));
      if (r < 86) return 16'($urandom_range(7, 20));
      if (r < 90) return 16'(dfr_pkg::MAX_PAYLOAD);
      if (r < 94) return 16'(dfr_pkg::MAX_PAYLOAD + 1);
      if (r < 97) return 16'hffff;
      return 16'($urandom_range(dfr_pkg::MAX_PAYLOAD + 2, 16'hfffe));
   endfunction

   // Drop valid, drain every expected result, then give the pipe time to go quiet
   task automatic settle();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_timeout(input logic [7:0] v);
      csr_ch.valid         <= 1'b1;
      csr_ch.timeout_ticks <= v;
      do @(posedge clock); while (!csr_ch.ready);
      sb.set_timeout(v);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // Random traffic: mostly well-formed messages with random content, plus
   // truncated frames left to time out, loose bytes and tick storms.
   task automatic run_phase(input int n_items);
      int          start;
      int          pick;
      logic [15:0] len;
      start = items_sent;
      while (items_sent - start < n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            len = pick_len();
            send_message(pick_code(), len, pick_word(), 4 + dfr_pkg::MAX_PAYLOAD, 1'b1);
            // pad after an odd length so the next message lands aligned, most of the time
            if (len <= dfr_pkg::MAX_PAYLOAD && len[0] && $urandom_range(0, 3) != 0) begin
               repeat (4) send_item(BEAT_BYTE, 8'($urandom_range(0, 255)));
            end
         end else if (pick < 85) begin
            len = 16'($urandom_range(0, 8));
            send_message(pick_code(), len, pick_word(), $urandom_range(1, 3 + len), 1'b0);
            send_ticks(sb.timeout + 1 + $urandom_range(0, 2));
         end else if (pick < 92) begin
            repeat ($urandom_range(1, 7)) begin
               if ($urandom_range(0, 5) == 0) send_item(BEAT_TICK, 8'h00);
               else send_item(BEAT_BYTE, 8'($urandom_range(0, 255)));
            end
         end else begin
            send_ticks($urandom_range(1, sb.timeout + 2));
         end
      end
   endtask

   initial begin
      sb         = new();
      items_sent = 0;
      burst_left = 0;
      rx_left    = 0;
      rx_mode    = RX_OPEN;
      rx_pattern = 16'hffff;
      clock      = 1'b0;
      reset      = 1'b1;

      req_ch.valid         = 1'b0;
      req_ch.kind          = 1'b0;
      req_ch.rx_byte       = 8'h00;
      rsp_ch.ready         = 1'b0;
      csr_ch.valid         = 1'b0;
      csr_ch.timeout_ticks = 8'h00;

      // Hold reset, then release it at a falling edge
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: idle tick, startup, general status with the pairing word,
      // pairing response, odd-length voice link update (word reads as 0),
      // then a header dropped as misaligned and a header over the buffer limit.
      send_item(BEAT_TICK, 8'h00);
      send_message(dfr_pkg::CODE_STARTUP, 16'd0, 16'h0000, 4, 1'b0);
      send_message(dfr_pkg::CODE_GENERAL, 16'd2, dfr_pkg::GENERAL_PAIRING, 6, 1'b0);
      send_message(dfr_pkg::CODE_PAIR_RSP, 16'd0, 16'h0000, 4, 1'b0);
      send_message(dfr_pkg::CODE_SCO_IND, 16'd1, 16'h0001, 5, 1'b0);
      send_message(16'hffff, 16'hffff, 16'h0000, 4, 1'b0);
      send_message(16'h0000, 16'(dfr_pkg::MAX_PAYLOAD + 1), 16'h0000, 4, 1'b0);
      settle();

      // Random phases across the timeout range, extremes included; the longest
      // timeout phase is kept short since one timed-out frame costs 256 ticks
      write_timeout(8'd1);
      run_phase(110);
      settle();
      write_timeout(8'($urandom_range(2, 40)));
      run_phase(120);
      settle();
      write_timeout(8'd255);
      run_phase(40);
      settle();
      write_timeout(dfr_pkg::TIMEOUT_RESET);
      run_phase(110);

      // Drain with a bound, then let the pipe run dry
      req_ch.valid <= 1'b0;
      for (int i = 0; i < 20000 && sb.pending() != 0; i++) @(negedge clock);
      repeat (8) @(negedge clock);
      sb.final_check();

      if (sb.errors == 0) begin
         $display("host_link_message_deframer_core_test: PASS");
      end else begin
         $display("host_link_message_deframer_core_test: FAIL");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run
   initial begin
      #2_000_000;
      $display("host_link_message_deframer_core_test: FAIL");
      $finish;
   end

endmodule
